// ===== rtl/core/qjt_pkg.sv =====
// shared types, constants and helpers of the quaternion joint transform
package qjt_pkg;

  localparam int QW        = 24;
  localparam int TW        = 32;
  localparam int PW        = 48;
  localparam int SW        = 49;
  localparam int AW        = 50;
  localparam int QTW       = 23;
  localparam int DIV_STEPS = 21;
  localparam int DIV_STG   = DIV_STEPS + 1;
  localparam int NENT      = 9;

  localparam logic [SW-1:0] NEAR_ZERO = 49'd1099512;
  localparam logic signed [63:0] ONE_Q40  = 64'sd1 <<< 40;
  localparam logic signed [63:0] HALF_Q20 = 64'sd1 <<< 19;
  localparam logic signed [63:0] ONE_Q20  = 64'sd1 <<< 20;
  localparam logic signed [63:0] R_MAX = 64'sd8388607;
  localparam logic signed [63:0] R_MIN = -64'sd8388608;
  localparam logic signed [63:0] T_MAX = 64'sd2147483647;
  localparam logic signed [63:0] T_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {
    ACT_FREE   = 2'd0,
    ACT_ROT    = 2'd1,
    ACT_SPHERE = 2'd2,
    ACT_RSVD   = 2'd3
  } qjt_act_e;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [QW-1:0]     q_w;
    logic signed [QW-1:0]     q_x;
    logic signed [QW-1:0]     q_y;
    logic signed [QW-1:0]     q_z;
    logic signed [TW-1:0]     t_x;
    logic signed [TW-1:0]     t_y;
    logic signed [TW-1:0]     t_z;
  } qjt_in_t;

  typedef struct packed {
    logic signed [QW-1:0] r00;
    logic signed [QW-1:0] r01;
    logic signed [QW-1:0] r02;
    logic signed [QW-1:0] r10;
    logic signed [QW-1:0] r11;
    logic signed [QW-1:0] r12;
    logic signed [QW-1:0] r20;
    logic signed [QW-1:0] r21;
    logic signed [QW-1:0] r22;
    logic signed [TW-1:0] out_x;
    logic signed [TW-1:0] out_y;
    logic signed [TW-1:0] out_z;
  } qjt_out_t;

  typedef struct packed {
    qjt_act_e                  act;
    logic signed [TW-1:0]      t_x;
    logic signed [TW-1:0]      t_y;
    logic signed [TW-1:0]      t_z;
    logic                      near;
    logic [NENT-1:0]           neg;
    logic [NENT-1:0][QW-1:0]   rfree;
  } qjt_side_t;

  function automatic logic signed [QW-1:0] sat24(input logic signed [63:0] v);
    logic signed [QW-1:0] res;
    if (v > R_MAX) res = 24'sh7fffff;
    else if (v < R_MIN) res = 24'sh800000;
    else res = v[QW-1:0];
    return res;
  endfunction

  function automatic logic signed [TW-1:0] sat32(input logic signed [63:0] v);
    logic signed [TW-1:0] res;
    if (v > T_MAX) res = 32'sh7fffffff;
    else if (v < T_MIN) res = 32'sh80000000;
    else res = v[TW-1:0];
    return res;
  endfunction

  function automatic logic is_diag(input int i);
    return (i % 4) == 0;
  endfunction

endpackage

// ===== rtl/core/qjt_stream_if.sv =====
// valid/ready stream channel with a typed payload
interface qjt_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/quaternion_joint_transform_unit.sv =====
// quaternion joint transform top level: pipeline and output skid stage
// an accepted input beat passes the product, divider and matrix stages, then the output register
// throughput: one beat per cycle while the skid register is empty, through the 22-stage nine-lane divider pipeline
// a stalled output holds the pipeline once the skid register is occupied
// reset clears all valid bits; payload registers are not reset
module quaternion_joint_transform_unit import qjt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  qjt_stream_if.sink    in_i,
  qjt_stream_if.source  out_o
);

  logic                     en;
  logic                     pv, dv, tail_vld;
  logic [NENT-1:0][AW-1:0]  a;
  logic [SW-1:0]            n;
  qjt_side_t                ps, ds;
  logic [NENT-1:0][QTW-1:0] q;
  qjt_out_t                 tail;
  qjt_out_t                 out_q, skid_q;
  logic                     out_vld_q, skid_vld_q;
  logic                     out_take;

  assign en       = !skid_vld_q;
  assign in_i.ready = en;
  assign out_take = out_vld_q && out_o.ready;

  qjt_prod u_prod (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_i.valid), .in_i(in_i.data),
    .vld_o(pv), .a_o(a), .n_o(n), .side_o(ps)
  );

  qjt_div u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(pv), .a_i(a), .n_i(n), .side_i(ps),
    .vld_o(dv), .q_o(q), .side_o(ds)
  );

  qjt_mat u_mat (
    .clk_i, .rst_ni, .en_i(en), .vld_i(dv), .q_i(q), .side_i(ds),
    .vld_o(tail_vld), .out_o(tail)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      out_vld_q <= 1'b1;
      if (out_take) skid_vld_q <= 1'b0;
    end else if (tail_vld) begin
      out_vld_q <= 1'b1;
      if (out_vld_q && !out_o.ready) skid_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) out_q <= skid_q;
    end else if (tail_vld) begin
      if (!out_vld_q || out_o.ready) out_q <= tail;
      else skid_q <= tail;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  a_skid_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid beat without output beat");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !out_o.ready |=> skid_vld_q && $stable(skid_q))
    else $error("skid beat lost while output stalled");

  a_tail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_vld && !en |=> tail_vld && $stable(tail))
    else $error("pipeline tail changed during stall");

endmodule

// ===== rtl/core/qjt_prod.sv =====
// quaternion products, entry sums, norm and divider operand preparation
module qjt_prod import qjt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  qjt_in_t                   in_i,
  output logic                      vld_o,
  output logic [NENT-1:0][AW-1:0]   a_o,
  output logic [SW-1:0]             n_o,
  output qjt_side_t                 side_o
);

  // stage 1: products ww xx yy zz xy wz xz wy yz wx
  logic signed [PW-1:0] pr_q [10];
  logic signed [PW-1:0] pr_d [10];
  qjt_in_t              in1_q;
  // stage 2: entry sums and norm
  logic signed [SW-1:0] p_q [NENT];
  logic signed [SW-1:0] p_d [NENT];
  logic [SW-1:0]        n_q, n_d;
  qjt_in_t              in2_q;
  // stage 3: operands
  logic [NENT-1:0][AW-1:0] a_q, a_d;
  logic [SW-1:0]           n3_q;
  qjt_side_t               side_q, side_d;
  logic [2:0]              v_q;

  always_comb begin
    pr_d[0] = in_i.q_w * in_i.q_w;
    pr_d[1] = in_i.q_x * in_i.q_x;
    pr_d[2] = in_i.q_y * in_i.q_y;
    pr_d[3] = in_i.q_z * in_i.q_z;
    pr_d[4] = in_i.q_x * in_i.q_y;
    pr_d[5] = in_i.q_w * in_i.q_z;
    pr_d[6] = in_i.q_x * in_i.q_z;
    pr_d[7] = in_i.q_w * in_i.q_y;
    pr_d[8] = in_i.q_y * in_i.q_z;
    pr_d[9] = in_i.q_w * in_i.q_x;
  end

  always_comb begin
    p_d[0] = SW'(pr_q[0]) + SW'(pr_q[1]);
    p_d[1] = SW'(pr_q[4]) - SW'(pr_q[5]);
    p_d[2] = SW'(pr_q[6]) + SW'(pr_q[7]);
    p_d[3] = SW'(pr_q[4]) + SW'(pr_q[5]);
    p_d[4] = SW'(pr_q[0]) + SW'(pr_q[2]);
    p_d[5] = SW'(pr_q[8]) - SW'(pr_q[9]);
    p_d[6] = SW'(pr_q[6]) - SW'(pr_q[7]);
    p_d[7] = SW'(pr_q[8]) + SW'(pr_q[9]);
    p_d[8] = SW'(pr_q[0]) + SW'(pr_q[3]);
    n_d = {2'b00, pr_q[0][PW-2:0]} + {2'b00, pr_q[1][PW-2:0]}
        + {2'b00, pr_q[2][PW-2:0]} + {2'b00, pr_q[3][PW-2:0]};
  end

  always_comb begin
    logic signed [SW-1:0] mag;
    logic signed [63:0]   v;
    side_d.act  = qjt_act_e'(in2_q.action);
    side_d.t_x  = in2_q.t_x;
    side_d.t_y  = in2_q.t_y;
    side_d.t_z  = in2_q.t_z;
    side_d.near = n_q < NEAR_ZERO;
    for (int i = 0; i < NENT; i++) begin
      side_d.neg[i] = p_q[i][SW-1];
      mag = p_q[i][SW-1] ? -p_q[i] : p_q[i];
      a_d[i] = {mag, 1'b0};
      v = 64'(p_q[i]) + HALF_Q20;
      if (is_diag(i)) v = v - ONE_Q40;
      side_d.rfree[i] = sat24(v >>> 20);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 10; i++) pr_q[i] <= pr_d[i];
      in1_q <= in_i;
      for (int i = 0; i < NENT; i++) p_q[i] <= p_d[i];
      n_q    <= n_d;
      in2_q  <= in1_q;
      a_q    <= a_d;
      n3_q   <= n_q;
      side_q <= side_d;
    end
  end

  assign vld_o  = v_q[2];
  assign a_o    = a_q;
  assign n_o    = n3_q;
  assign side_o = side_q;

endmodule

// ===== rtl/core/qjt_div.sv =====
// nine-lane restoring divider, integer part in the first stage, then one quotient bit per stage
module qjt_div import qjt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [NENT-1:0][AW-1:0]   a_i,
  input  logic [SW-1:0]             n_i,
  input  qjt_side_t                 side_i,
  output logic                      vld_o,
  output logic [NENT-1:0][QTW-1:0]  q_o,
  output qjt_side_t                 side_o
);

  logic [NENT-1:0][AW-1:0]  r_q [DIV_STG];
  logic [NENT-1:0][AW-1:0]  r_d [DIV_STG];
  logic [NENT-1:0][QTW-1:0] q_q [DIV_STG];
  logic [NENT-1:0][QTW-1:0] q_d [DIV_STG];
  logic [SW-1:0]            n_q [DIV_STG];
  qjt_side_t                s_q [DIV_STG];
  logic [DIV_STG-1:0]       v_q;

  // integer part, quotient is at most two since the dividend never exceeds 2n
  // then one fraction bit per stage
  always_comb begin
    logic [AW-1:0] n1, n2;
    logic [AW-1:0] r2, nn;
    n1 = {1'b0, n_i};
    n2 = {n_i, 1'b0};
    for (int i = 0; i < NENT; i++) begin
      if (a_i[i] >= n2) begin
        q_d[0][i] = QTW'(2);
        r_d[0][i] = a_i[i] - n2;
      end else if (a_i[i] >= n1) begin
        q_d[0][i] = QTW'(1);
        r_d[0][i] = a_i[i] - n1;
      end else begin
        q_d[0][i] = '0;
        r_d[0][i] = a_i[i];
      end
    end
    for (int k = 1; k < DIV_STG; k++) begin
      nn = {1'b0, n_q[k-1]};
      for (int i = 0; i < NENT; i++) begin
        r2 = {r_q[k-1][i][AW-2:0], 1'b0};
        if (r2 >= nn) begin
          r_d[k][i] = r2 - nn;
          q_d[k][i] = {q_q[k-1][i][QTW-2:0], 1'b1};
        end else begin
          r_d[k][i] = r2;
          q_d[k][i] = {q_q[k-1][i][QTW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DIV_STG-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0] <= n_i;
      s_q[0] <= side_i;
      for (int k = 0; k < DIV_STG; k++) begin
        r_q[k] <= r_d[k];
        q_q[k] <= q_d[k];
      end
      for (int k = 1; k < DIV_STG; k++) begin
        n_q[k] <= n_q[k-1];
        s_q[k] <= s_q[k-1];
      end
    end
  end

  assign vld_o  = v_q[DIV_STG-1];
  assign q_o    = q_q[DIV_STG-1];
  assign side_o = s_q[DIV_STG-1];

endmodule

// ===== rtl/core/qjt_mat.sv =====
// rotation rounding and selection, then rotation times translation
module qjt_mat import qjt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [NENT-1:0][QTW-1:0]  q_i,
  input  qjt_side_t                 side_i,
  output logic                      vld_o,
  output qjt_out_t                  out_o
);

  localparam int MW = QW + TW;

  logic signed [QW-1:0]  r1_q [NENT];
  logic signed [QW-1:0]  r1_d [NENT];
  logic signed [QW-1:0]  r2_q [NENT];
  logic signed [MW-1:0]  m_q  [NENT];
  logic signed [MW-1:0]  m_d  [NENT];
  logic signed [TW-1:0]  t1_q [3];
  logic signed [TW-1:0]  t2_q [3];
  qjt_act_e              act1_q, act2_q;
  qjt_out_t              out_q, out_d;
  logic [2:0]            v_q;

  always_comb begin
    logic [QTW-1:0]     qs;
    logic signed [63:0] v;
    for (int i = 0; i < NENT; i++) begin
      qs = QTW'(({1'b0, q_i[i]} + 24'd1) >> 1);
      v  = side_i.neg[i] ? -64'(qs) : 64'(qs);
      if (is_diag(i)) v = v - ONE_Q20;
      if (side_i.act != ACT_ROT) r1_d[i] = $signed(side_i.rfree[i]);
      else if (side_i.near) r1_d[i] = is_diag(i) ? 24'sh100000 : 24'sh000000;
      else r1_d[i] = sat24(v);
    end
  end

  always_comb begin
    for (int i = 0; i < NENT; i++) m_d[i] = MW'(r1_q[i]) * MW'(t1_q[i % 3]);
  end

  always_comb begin
    logic signed [63:0] acc;
    logic signed [TW-1:0] o [3];
    for (int row = 0; row < 3; row++) begin
      acc = 64'(m_q[row*3]) + 64'(m_q[row*3+1]) + 64'(m_q[row*3+2]) + HALF_Q20;
      case (act2_q)
        ACT_ROT:    o[row] = sat32(acc >>> 20);
        ACT_SPHERE: o[row] = '0;
        default:    o[row] = t2_q[row];
      endcase
    end
    out_d.r00   = r2_q[0];
    out_d.r01   = r2_q[1];
    out_d.r02   = r2_q[2];
    out_d.r10   = r2_q[3];
    out_d.r11   = r2_q[4];
    out_d.r12   = r2_q[5];
    out_d.r20   = r2_q[6];
    out_d.r21   = r2_q[7];
    out_d.r22   = r2_q[8];
    out_d.out_x = o[0];
    out_d.out_y = o[1];
    out_d.out_z = o[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NENT; i++) begin
        r1_q[i] <= r1_d[i];
        r2_q[i] <= r1_q[i];
        m_q[i]  <= m_d[i];
      end
      t1_q[0] <= side_i.t_x;
      t1_q[1] <= side_i.t_y;
      t1_q[2] <= side_i.t_z;
      for (int j = 0; j < 3; j++) t2_q[j] <= t1_q[j];
      act1_q <= side_i.act;
      act2_q <= act1_q;
      out_q  <= out_d;
    end
  end

  assign vld_o = v_q[2];
  assign out_o = out_q;

endmodule

// ===== verif/quaternion_joint_transform_unit_tb.sv =====
// self-checking testbench of the quaternion joint transform unit
module quaternion_joint_transform_unit_tb;
  import qjt_pkg::*;

  logic clk_i;
  logic rst_ni;

  qjt_stream_if #(.T(qjt_in_t))  pose_if ();
  qjt_stream_if #(.T(qjt_out_t)) xform_if ();

  quaternion_joint_transform_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pose_if.sink),
    .out_o  (xform_if.source)
  );

  localparam int NUM_RANDOM = 1200;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 400;

  qjt_out_t xform_q[$];
  int fail_cnt = 0;
  int idle_cycles = 0;
  bit stim_done = 0;
  bit hold_done = 0;
  int beats_in = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic signed [63:0] floor_div20(input logic signed [63:0] v);
    return v >>> 20;
  endfunction

  function automatic logic signed [63:0] div_round(input logic signed [63:0] num,
                                                   input logic signed [63:0] n);
    logic [127:0] a;
    logic [127:0] q;
    logic [127:0] r;
    a = (num < 0) ? -num : num;
    a = a << 20;
    q = a / n;
    r = a % n;
    q = (q << 1) | ((r << 1) >= n ? 1 : 0);
    q = (q + 1) >> 1;
    return (num < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic qjt_out_t joint_xform(input qjt_in_t b);
    logic signed [63:0] w, x, y, z, n, v, acc;
    logic signed [63:0] p[9];
    logic signed [63:0] r[9];
    logic signed [63:0] t[3];
    logic signed [63:0] o[3];
    qjt_out_t res;
    w = 64'(b.q_w); x = 64'(b.q_x); y = 64'(b.q_y); z = 64'(b.q_z);
    t[0] = 64'(b.t_x); t[1] = 64'(b.t_y); t[2] = 64'(b.t_z);
    p[0] = w*w + x*x; p[1] = x*y - w*z; p[2] = x*z + w*y;
    p[3] = x*y + w*z; p[4] = w*w + y*y; p[5] = y*z - w*x;
    p[6] = x*z - w*y; p[7] = y*z + w*x; p[8] = w*w + z*z;
    if (b.action == ACT_ROT) begin
      n = w*w + x*x + y*y + z*z;
      for (int i = 0; i < 9; i++) begin
        if (n < 64'sd1099512) r[i] = (i % 4 == 0) ? ONE_Q20 : 0;
        else begin
          v = div_round(2 * p[i], n);
          if (i % 4 == 0) v -= ONE_Q20;
          r[i] = sat24(v);
        end
      end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += r[i*3+j] * t[j];
        o[i] = sat32(floor_div20(acc + HALF_Q20));
      end
    end else begin
      for (int i = 0; i < 9; i++) begin
        v = p[i];
        if (i % 4 == 0) v -= ONE_Q40;
        r[i] = sat24(floor_div20(v + HALF_Q20));
      end
      for (int i = 0; i < 3; i++) o[i] = (b.action == ACT_SPHERE) ? 0 : t[i];
    end
    res.r00 = QW'(r[0]); res.r01 = QW'(r[1]); res.r02 = QW'(r[2]);
    res.r10 = QW'(r[3]); res.r11 = QW'(r[4]); res.r12 = QW'(r[5]);
    res.r20 = QW'(r[6]); res.r21 = QW'(r[7]); res.r22 = QW'(r[8]);
    res.out_x = TW'(o[0]); res.out_y = TW'(o[1]); res.out_z = TW'(o[2]);
    return res;
  endfunction

  function automatic qjt_in_t mk_pose(input logic [1:0] a, input int w, input int x,
                                      input int y, input int z, input int tx,
                                      input int ty, input int tz);
    qjt_in_t b;
    b.action = a; b.q_w = QW'(w); b.q_x = QW'(x); b.q_y = QW'(y); b.q_z = QW'(z);
    b.t_x = tx; b.t_y = ty; b.t_z = tz;
    return b;
  endfunction

  function automatic qjt_in_t rand_pose();
    qjt_in_t b;
    int sel;
    b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    sel = $urandom_range(0, 9);
    b.action = (sel < 4) ? ACT_ROT : (sel < 6) ? ACT_FREE : (sel < 8) ? ACT_SPHERE : sel == 8 ?
               ACT_RSVD : $urandom_range(0, 3);
    case ($urandom_range(0, 5))
      0: begin
        b.q_w = $signed(b.q_w) >>> $urandom_range(0, 23);
        b.q_x = $signed(b.q_x) >>> $urandom_range(0, 23);
        b.q_y = $signed(b.q_y) >>> $urandom_range(0, 23);
        b.q_z = $signed(b.q_z) >>> $urandom_range(0, 23);
      end
      1: begin
        b.q_w = $signed(b.q_w) >>> 21; b.q_x = $signed(b.q_x) >>> 21;
        b.q_y = $signed(b.q_y) >>> 21; b.q_z = $signed(b.q_z) >>> 21;
      end
      2: begin
        b.t_x = $signed(b.t_x) >>> 12; b.t_y = $signed(b.t_y) >>> 12;
        b.t_z = $signed(b.t_z) >>> 12;
      end
      default: ;
    endcase
    return b;
  endfunction

  // directed table: pose and, where obvious, the typed-in result
  typedef struct {
    qjt_in_t  pose;
    bit       typed;
    qjt_out_t xform;
  } pose_row_t;

  pose_row_t dir_tbl[$];

  task automatic add_row(input qjt_in_t b, input bit typed = 0,
                         input qjt_out_t x = '0);
    pose_row_t row;
    row.pose = b; row.typed = typed; row.xform = x;
    dir_tbl.push_back(row);
  endtask

  task automatic send_pose(input qjt_in_t b, input qjt_out_t x);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      pose_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pose_if.valid <= 1'b1;
    pose_if.data  <= b;
    @(posedge clk_i);
    while (!pose_if.ready) @(posedge clk_i);
    xform_q.push_back(x);
  endtask

  initial begin
    qjt_out_t id_x;
    qjt_in_t b;
    pose_if.valid = 1'b0;
    pose_if.data  = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity with the sqrt(2) scale: w = sqrt(2) ~ 1482910
    id_x = '0;
    id_x.r00 = 24'sd1048576; id_x.r11 = 24'sd1048576; id_x.r22 = 24'sd1048576;
    id_x.out_x = 32'sd65536; id_x.out_y = -32'sd65536; id_x.out_z = 32'sd7;
    // near-zero quaternion in rotate-displace mode gives identity and T
    add_row(mk_pose(ACT_ROT, 0, 0, 0, 0, 65536, -65536, 7), 1, id_x);
    add_row(mk_pose(ACT_ROT, 1, -1, 1, 1, 65536, -65536, 7), 1, id_x);
    add_row(mk_pose(ACT_ROT, 1048, 0, 0, 0, 65536, -65536, 7));
    add_row(mk_pose(ACT_ROT, 1049, 0, 0, 0, 65536, -65536, 7));
    id_x.out_x = 32'sd0; id_x.out_y = 32'sd0; id_x.out_z = 32'sd0;
    id_x.r00 = -24'sd1048576; id_x.r11 = -24'sd1048576; id_x.r22 = -24'sd1048576;
    // zero quaternion in free, sphere and reserved modes gives minus one on the diagonal
    add_row(mk_pose(ACT_SPHERE, 0, 0, 0, 0, -1, 5, 9), 1, id_x);
    id_x.out_x = 32'h80000000; id_x.out_y = 32'h7fffffff; id_x.out_z = 32'sd1;
    add_row(mk_pose(ACT_FREE, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 1), 1, id_x);
    add_row(mk_pose(ACT_RSVD, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 1), 1, id_x);
    for (int a = 0; a < 4; a++) begin
      add_row(mk_pose(a, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      add_row(mk_pose(a, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
                      32'h80000000, 32'h80000000, 32'h80000000));
      add_row(mk_pose(a, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff,
                      32'h7fffffff, 32'h80000000, 32'h7fffffff));
      add_row(mk_pose(a, 1482910, 0, 0, 0, 65536, 131072, -65536));
    end
    add_row(mk_pose(ACT_ROT, 1048576, 1048576, 1048576, 1048576, 32'h7fffffff,
                    32'h7fffffff, 32'h7fffffff));
    add_row(mk_pose(ACT_ROT, 0, 0, 0, 24'h800000, 32'h80000000, 0, 0));

    foreach (dir_tbl[i])
      send_pose(dir_tbl[i].pose, dir_tbl[i].typed ? dir_tbl[i].xform
                                                  : joint_xform(dir_tbl[i].pose));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      b = rand_pose();
      send_pose(b, joint_xform(b));
      beats_in++;
    end
    pose_if.valid <= 1'b0;
    stim_done = 1;
  end

  // receiver: random stalls plus one long hold-off mid-run
  initial begin
    int gap;
    xform_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && beats_in > 300) begin
        hold_done = 1;
        xform_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      gap = $urandom_range(0, 9);
      if (gap > 0) begin
        xform_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      xform_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    qjt_out_t exp_x;
    qjt_out_t got;
    if (rst_ni && xform_if.valid && xform_if.ready) begin
      got = xform_if.data;
      if (xform_q.size() == 0) begin
        $error("unexpected result beat");
        fail_cnt++;
      end else begin
        exp_x = xform_q.pop_front();
        if (got.r00 !== exp_x.r00) begin
          $error("r00 exp %0d got %0d", exp_x.r00, got.r00); fail_cnt++;
        end
        if (got.r01 !== exp_x.r01) begin
          $error("r01 exp %0d got %0d", exp_x.r01, got.r01); fail_cnt++;
        end
        if (got.r02 !== exp_x.r02) begin
          $error("r02 exp %0d got %0d", exp_x.r02, got.r02); fail_cnt++;
        end
        if (got.r10 !== exp_x.r10) begin
          $error("r10 exp %0d got %0d", exp_x.r10, got.r10); fail_cnt++;
        end
        if (got.r11 !== exp_x.r11) begin
          $error("r11 exp %0d got %0d", exp_x.r11, got.r11); fail_cnt++;
        end
        if (got.r12 !== exp_x.r12) begin
          $error("r12 exp %0d got %0d", exp_x.r12, got.r12); fail_cnt++;
        end
        if (got.r20 !== exp_x.r20) begin
          $error("r20 exp %0d got %0d", exp_x.r20, got.r20); fail_cnt++;
        end
        if (got.r21 !== exp_x.r21) begin
          $error("r21 exp %0d got %0d", exp_x.r21, got.r21); fail_cnt++;
        end
        if (got.r22 !== exp_x.r22) begin
          $error("r22 exp %0d got %0d", exp_x.r22, got.r22); fail_cnt++;
        end
        if (got.out_x !== exp_x.out_x) begin
          $error("out_x exp %0d got %0d", exp_x.out_x, got.out_x); fail_cnt++;
        end
        if (got.out_y !== exp_x.out_y) begin
          $error("out_y exp %0d got %0d", exp_x.out_y, got.out_y); fail_cnt++;
        end
        if (got.out_z !== exp_x.out_z) begin
          $error("out_z exp %0d got %0d", exp_x.out_z, got.out_z); fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat, and the end of the run
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((pose_if.valid && pose_if.ready) || (xform_if.valid && xform_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
      if (stim_done && xform_q.size() == 0) begin
        repeat (40) @(posedge clk_i);
        if (fail_cnt == 0 && xform_q.size() == 0) begin
          $display("== PASS ==");
        end else begin
          $display("== FAIL ==");
        end
        $finish;
      end
    end
  end

endmodule

// ===== quaternion_joint_transform_unit.f =====
rtl/core/qjt_pkg.sv
rtl/core/qjt_stream_if.sv
rtl/core/qjt_prod.sv
rtl/core/qjt_div.sv
rtl/core/qjt_mat.sv
rtl/core/quaternion_joint_transform_unit.sv
verif/quaternion_joint_transform_unit_tb.sv
